/* rtl/dtoi_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the decimal text to integer converter.
// No dependencies; imported by every module of the block.
package dtoi_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned MagW   = 32;
  localparam int unsigned ValueW = MagW + 1;
  localparam int unsigned PhaseW = 2;

  // Scanner phase codes
  localparam logic [PhaseW-1:0] PhLead    = 2'd0;
  localparam logic [PhaseW-1:0] PhDigits  = 2'd1;
  localparam logic [PhaseW-1:0] PhStopped = 2'd2;
  localparam logic [PhaseW-1:0] PhFailed  = 2'd3;

  // Characters the scanner recognizes
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;

  localparam logic [MagW-1:0] PosLimit = 32'h7FFF_FFFF;
  localparam logic [MagW-1:0] NegLimit = 32'h8000_0000;

  // Everything the result stage needs about one finished text
  typedef struct packed {
    logic            failed;
    logic            minus;
    logic            signed_mode;
    logic [MagW-1:0] mag;
  } fin_t;

endpackage

/* rtl/dtoi_scan.sv */
`timescale 1ns / 1ps
// Character scanner: phase, sign and magnitude state, one character per step.
// Depends on dtoi_pkg.
module dtoi_scan import dtoi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  input  logic             signed_mode_i,
  output fin_t             fin_o,
  output logic [PhaseW-1:0] phase_o
);

  logic [PhaseW-1:0] phase_q, phase_d, phase_nx;
  logic [MagW-1:0]   mag_q, mag_d, mag_nx, mag_step;
  logic              minus_q, minus_d, minus_nx;
  logic              is_digit, is_sep;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_sep   = (char_i == ChComma) || (char_i == ChDot);
  // times ten as shift-add, digit value from the low nibble
  assign mag_step = {mag_q[MagW-4:0], 3'b000} + {mag_q[MagW-2:0], 1'b0}
                  + {{(MagW-4){1'b0}}, char_i[3:0]};

  always_comb begin
    phase_nx = phase_q;
    mag_nx   = mag_q;
    minus_nx = minus_q;
    unique case (phase_q)
      PhLead: begin
        if (char_i == ChSpace) begin
          phase_nx = PhLead;
        end else if ((char_i == ChPlus) || (char_i == ChMinus)) begin
          minus_nx = (char_i == ChMinus);
          phase_nx = PhDigits;
        end else if (is_digit) begin
          mag_nx   = mag_step;
          phase_nx = PhDigits;
        end else if (is_sep) begin
          phase_nx = PhStopped;
        end else begin
          phase_nx = PhFailed;
        end
      end
      PhDigits: begin
        if (is_digit) begin
          mag_nx = mag_step;
        end else if (is_sep || (char_i == ChSpace)) begin
          phase_nx = PhStopped;
        end else begin
          phase_nx = PhFailed;
        end
      end
      PhStopped, PhFailed: begin
        phase_nx = phase_q;
      end
      default: phase_nx = phase_q;
    endcase
  end

  // Drop back to the leading phase after the last character of a text
  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    minus_d = minus_q;
    if (step_i) begin
      if (last_i) begin
        phase_d = PhLead;
        mag_d   = '0;
        minus_d = 1'b0;
      end else begin
        phase_d = phase_nx;
        mag_d   = mag_nx;
        minus_d = minus_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      mag_q   <= '0;
      minus_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      minus_q <= minus_d;
    end
  end

  assign fin_o.failed      = (phase_nx == PhFailed);
  assign fin_o.minus       = minus_nx;
  assign fin_o.signed_mode = signed_mode_i;
  assign fin_o.mag         = mag_nx;
  assign phase_o           = phase_q;

endmodule

/* rtl/dtoi_result.sv */
`timescale 1ns / 1ps
// Result formatter: range check and negation of a finished magnitude.
// Depends on dtoi_pkg.
module dtoi_result import dtoi_pkg::*; (
  input  fin_t              fin_i,
  output logic              ok_o,
  output logic [ValueW-1:0] value_o
);

  logic [ValueW-1:0] mag_ext;

  assign mag_ext = {1'b0, fin_i.mag};

  always_comb begin
    ok_o    = 1'b0;
    value_o = '0;
    if (!fin_i.failed) begin
      if (!fin_i.signed_mode) begin
        ok_o    = 1'b1;
        value_o = mag_ext;
      end else if (fin_i.minus) begin
        if (fin_i.mag <= NegLimit) begin
          ok_o    = 1'b1;
          value_o = '0 - mag_ext;
        end
      end else if (fin_i.mag <= PosLimit) begin
        ok_o    = 1'b1;
        value_o = mag_ext;
      end
    end
  end

endmodule

/* rtl/decimal_text_to_integer.sv */
`timescale 1ns / 1ps
// Decimal text to integer converter, top level. Depends on dtoi_pkg, dtoi_scan, dtoi_result.
// Throughput: one character word per cycle, sustained; a last character waits while the
//   finish register is full and cannot advance to a stalled result register.
// Path of a text's result: input register -> scanner/finish register -> result register.
// Reset: asynchronous, active low; clears all valid flags and the scanner, signed_mode goes to 1.
module decimal_text_to_integer import dtoi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: signed_mode
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_char
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [32:0] number_value, [39:33] zero
  output logic        m_axis_tuser    // [0] parse_ok
);

  // Configuration register
  logic signed_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  // Pipeline control
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             fin_valid_q, fin_valid_d;
  fin_t             fin_q, scan_fin;
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q, res_ok;
  logic [ValueW-1:0] out_value_q, res_value;
  logic             s_accept, scan_step, fin_adv, fin_free, out_free;
  logic [PhaseW-1:0] scan_phase;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  // Output slot opens when empty or when the held word is taken this cycle
  assign out_free  = !out_valid_q || m_axis_tready;
  assign fin_adv   = fin_valid_q && out_free;
  assign fin_free  = !fin_valid_q || fin_adv;
  // Non-last characters only touch scanner state, so they never wait on the output side
  assign scan_step = in_valid_q && (!in_last_q || fin_free);
  assign s_axis_tready = !in_valid_q || scan_step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (scan_step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (scan_step && in_last_q) begin
      fin_valid_d = 1'b1;
    end else if (fin_adv) begin
      fin_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (scan_step && in_last_q) begin
      fin_q <= scan_fin;
    end
    if (fin_adv) begin
      out_ok_q    <= res_ok;
      out_value_q <= res_value;
    end
  end

  dtoi_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (scan_step),
    .char_i        (in_char_q),
    .last_i        (in_last_q),
    .signed_mode_i (signed_mode_q),
    .fin_o         (scan_fin),
    .phase_o       (scan_phase)
  );

  dtoi_result u_result (
    .fin_i   (fin_q),
    .ok_o    (res_ok),
    .value_o (res_value)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(40-ValueW){1'b0}}, out_value_q};
  assign m_axis_tuser  = out_ok_q;

  // A failed parse always reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero value on failed parse");

  // A finished text never overwrites one still waiting for the output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !fin_adv |-> !(scan_step && in_last_q))
    else $error("finish register overrun");

  // The scanner restarts in the leading phase after each last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_step && in_last_q |=> scan_phase == PhLead)
    else $error("scanner not cleared after last character");

  // A held result stays valid until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("result dropped while stalled");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for decimal_text_to_integer: streams character words, predicts
// each parsed result in-line and compares every result word. Depends on dtoi_pkg and the RTL.
module tb;
  import dtoi_pkg::*;

  localparam int IdleLimit  = 1000;  // cycles with no word moving on either side
  localparam int DrainTicks = 4;     // idle ticks added after the last expected result comes out

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] value;
  } parse_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_byte
  logic        s_axis_tlast;   // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [32:0] number_value, [39:33] zero
  logic        m_axis_tuser;   // [0] parse_ok

  decimal_text_to_integer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow of the converter: configuration and per-text scan state
  logic              mode_signed;
  logic [PhaseW-1:0] text_phase;
  logic [MagW-1:0]   text_mag;
  logic              text_minus;

  parse_result_t expected_results[$];
  logic [7:0]    text_buf[$];
  int            mismatches;
  int            sent_words;
  int            burst_left;
  int            gap_max;
  bit            stall_enable;
  int            ready_run;
  int            idle_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [39:0] got,
                                 input logic [39:0] want);
    if (mismatches < 100) begin
      $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
    end
    mismatches++;
  endtask

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= ChZero && ch <= ChNine;
  endfunction

  // Advance the shadow scanner by one character; queue a result on the last one.
  function automatic void scan_char(input logic [7:0] ch, input logic last);
    parse_result_t res;
    if (text_phase == PhLead) begin
      if (ch == ChSpace) begin
        text_phase = PhLead;
      end else if (ch == ChPlus || ch == ChMinus) begin
        text_minus = (ch == ChMinus);
        text_phase = PhDigits;
      end else if (is_digit(ch)) begin
        text_mag   = text_mag * 32'd10 + MagW'(ch - ChZero);
        text_phase = PhDigits;
      end else if (ch == ChComma || ch == ChDot) begin
        text_phase = PhStopped;
      end else begin
        text_phase = PhFailed;
      end
    end else if (text_phase == PhDigits) begin
      if (is_digit(ch)) begin
        text_mag = text_mag * 32'd10 + MagW'(ch - ChZero);
      end else if (ch == ChComma || ch == ChDot || ch == ChSpace) begin
        text_phase = PhStopped;
      end else begin
        text_phase = PhFailed;
      end
    end
    if (last) begin
      res = '0;
      if (text_phase != PhFailed) begin
        if (!mode_signed) begin
          res.ok    = 1'b1;
          res.value = {1'b0, text_mag};
        end else if (text_minus) begin
          // magnitude up to 2^31 is allowed when negative
          if (text_mag <= NegLimit) begin
            res.ok    = 1'b1;
            res.value = ValueW'(0) - {1'b0, text_mag};
          end
        end else if (text_mag <= PosLimit) begin
          res.ok    = 1'b1;
          res.value = {1'b0, text_mag};
        end
      end
      expected_results.push_back(res);
      text_phase = PhLead;
      text_mag   = '0;
      text_minus = 1'b0;
    end
  endfunction

  // Send one character word; idle between bursts when gaps are enabled.
  task automatic send_word(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
    scan_char(ch, last);
  endtask

  task automatic send_bytes(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) begin
      send_word(txt[i], i == txt.size() - 1);
    end
  endtask

  task automatic send_string(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s[i]);
    end
    send_bytes(txt);
  endtask

  // Hold the input idle until every expected result has come out and the pipe is empty.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);
  endtask

  task automatic write_signed_mode(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_signed = value;
  endtask

  // Mostly characters the scanner reacts to, the rest any byte at all.
  function automatic logic [7:0] noise_char();
    logic [7:0] specials[9];
    specials = '{ChSpace, ChPlus, ChMinus, ChComma, ChDot, ChZero, ChNine, 8'h2F, 8'h3A};
    if ($urandom_range(0, 1) != 0) begin
      return specials[$urandom_range(0, 8)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Fill text_buf with one text: mostly well-formed numbers, some broken, some noise.
  function automatic void build_text();
    longint bounds[7];
    longint v;
    string  digits;
    int     kind;
    logic [7:0] seps[3];
    bounds = '{64'd0, 64'd9, 64'd2147483647, 64'd2147483648,
               64'd4294967295, 64'd4294967296, 64'd9999999999};
    seps   = '{ChComma, ChDot, ChSpace};
    kind   = $urandom_range(0, 99);
    text_buf.delete();
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(noise_char());
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(ChSpace);
    end
    case ($urandom_range(0, 3))
      0: text_buf.push_back(ChPlus);
      1: text_buf.push_back(ChMinus);
      default: ;
    endcase
    if ($urandom_range(0, 19) != 0) begin
      if ($urandom_range(0, 1) != 0) begin
        // land on and around the range limits of both modes
        v = bounds[$urandom_range(0, 6)] + longint'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) text_buf.push_back(digits[i]);
      end else begin
        // up to twelve digits, so the magnitude wraps now and then
        repeat ($urandom_range(1, 12)) text_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      text_buf.push_back(seps[$urandom_range(0, 2)]);
      repeat ($urandom_range(0, 3)) text_buf.push_back(noise_char());
    end
    if (text_buf.size() == 0) text_buf.push_back(ChSpace);
    // break a few texts with one stray character
    if (kind < 30) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = noise_char();
    end
  endfunction

  // Check every result word against the oldest prediction; drive the receiver stalls.
  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", m_axis_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.ok) begin
          report_mismatch("parse_ok", 40'(m_axis_tuser), 40'(want.ok));
        end
        if (m_axis_tdata[ValueW-1:0] !== want.value) begin
          report_mismatch("number_value", 40'(m_axis_tdata[ValueW-1:0]), 40'(want.value));
        end
        if (m_axis_tdata[39:ValueW] !== '0) begin
          report_mismatch("tdata padding", 40'(m_axis_tdata[39:ValueW]), '0);
        end
      end
    end
    if (ready_run == 0) begin
      if (stall_enable && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        ready_run = $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b1;
        ready_run = $urandom_range(1, 20);
      end
    end
    ready_run--;
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Reset value of signed_mode: the negative range limit, lone separator, sign only,
  // doubled sign and a byte outside the character set.
  task automatic test_signed_directed();
    send_string("-2147483648");
    send_string(",");
    send_string(" -");
    send_string("-+");
    send_bytes('{8'hFF});
  endtask

  // Largest unsigned value, written after switching to unsigned.
  task automatic test_unsigned_directed();
    wait_for_drain();
    write_signed_mode(1'b0);
    send_string("4294967295");
  endtask

  // Flip the mode with a text half sent; the mode at its last character rules.
  task automatic test_mode_change_mid_text();
    wait_for_drain();
    write_signed_mode(1'b1);
    send_word(ChMinus, 1'b0);
    send_word(ChZero + 8'd1, 1'b0);
    wait_for_drain();
    write_signed_mode(1'b0);
    send_word(ChZero + 8'd3, 1'b1);
    send_word(ChMinus, 1'b0);
    send_word(ChNine, 1'b0);
    wait_for_drain();
    write_signed_mode(1'b1);
    send_word(ChNine, 1'b1);
  endtask

  // Random texts in six phases, alternating the mode and the idle patterns.
  task automatic test_random_texts();
    int phase_end;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_drain();
      write_signed_mode(phase % 2 == 0);
      gap_max      = (phase == 0 || phase == 2) ? 0 : $urandom_range(2, 12);
      stall_enable = (phase != 0 && phase != 3);
      phase_end    = sent_words + 235;
      while (sent_words < phase_end) begin
        build_text();
        send_bytes(text_buf);
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    mode_signed   = 1'b1;
    text_phase    = PhLead;
    text_mag      = '0;
    text_minus    = 1'b0;
    mismatches    = 0;
    sent_words    = 0;
    burst_left    = 0;
    gap_max       = 4;
    stall_enable  = 1'b1;
    ready_run     = 0;
    idle_cycles   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_signed_directed();
    test_unsigned_directed();
    test_mode_change_mid_text();
    test_random_texts();
    wait_for_drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
